>>> rtl/gdsc_pkg.sv
package gdsc_pkg;

  // Command codes carried with each item
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // Frame words before they are fitted to the frame length
  localparam logic [15:0] READ_CMD_BASE = 16'h807F;
  localparam logic [15:0] DUMMY_WORD    = 16'hFFFF;

  localparam int unsigned ADDR_LSB = 11;

  localparam logic [7:0] HALF_PERIOD_RESET = 8'd10;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  reg_addr;
    logic [10:0] write_data;
    logic [2:0]  miso_samples;
  } gdsc_item_t;

  typedef struct packed {
    logic        cs_n;
    logic        sck;
    logic        mosi;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_data;
  } gdsc_res_t;

endpackage

>>> rtl/gate_driver_spi_command_master_unit.sv
// Tick-driven SPI command master for a 16-bit register-mapped gate driver. Every input item is
// one timing tick and yields exactly one result item with the pin levels (cs_n, sck, mosi), the
// busy and done flags, and the last received word. A write command sends one frame; a read of a
// nonzero address sends the command frame, a one-tick chip-select gap, then an all-ones dummy
// frame whose received word is the answer. Each bit takes 1 + 2 * half_period_ticks ticks, a
// zero half period counting as one. The block takes one item per clock cycle while it does not
// stall; each result passes through the input register, then the sequencer result register,
// before it is offered on the output. It stalls only while the result register is held by the
// downstream side. Write half_period_ticks only while no command runs.
module gate_driver_spi_command_master_unit #(
  parameter int unsigned FRAME_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // reg_addr[3:0], write_data[14:4], miso_samples[17:15], zero fill [23:18]
  input  logic [23:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cs_n[0], sck[1], mosi[2], busy_res[3], done_res[4], read_data[20:5], zero fill [23:21]
  output logic [23:0] m_axis_tdata
);
  import gdsc_pkg::*;

  gdsc_item_t s_item;
  gdsc_item_t held_item;
  gdsc_res_t  res;
  logic       held_valid;
  logic       take;

  always_comb begin
    s_item.cmd          = s_axis_tuser;
    s_item.reg_addr     = s_axis_tdata[3:0];
    s_item.write_data   = s_axis_tdata[14:4];
    s_item.miso_samples = s_axis_tdata[17:15];
  end

  gdsc_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (s_item),
    .take_i  (take),
    .valid_o (held_valid),
    .item_o  (held_item)
  );

  gdsc_seq #(
    .FRAME_BITS (FRAME_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (held_valid),
    .item_i      (held_item),
    .take_o      (take),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {3'b000, res.read_data, res.done_res, res.busy_res,
                         res.mosi, res.sck, res.cs_n};

endmodule

>>> rtl/gdsc_in_reg.sv
module gdsc_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  gdsc_pkg::gdsc_item_t item_i,
  input  logic               take_i,
  output logic               valid_o,
  output gdsc_pkg::gdsc_item_t item_o
);
  import gdsc_pkg::*;

  logic       valid_q;
  gdsc_item_t item_q;

  // Refill when empty or whenever the held item leaves in this cycle
  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

>>> rtl/gdsc_seq.sv
module gdsc_seq #(
  parameter int unsigned FRAME_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  input  gdsc_pkg::gdsc_item_t item_i,
  output logic                 take_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output gdsc_pkg::gdsc_res_t  res_o
);
  import gdsc_pkg::*;

  localparam int unsigned CntW = $clog2(FRAME_BITS);
  localparam logic [CntW-1:0] LastBit = CntW'(FRAME_BITS - 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SETUP,
    PH_HIGH,
    PH_LOW,
    PH_GAP
  } phase_e;

  logic [7:0]            half_q;
  phase_e                phase_q, phase_d;
  logic [CntW-1:0]       bit_q, bit_d;
  logic [FRAME_BITS-1:0] tx_q, tx_d;
  logic [FRAME_BITS-1:0] rx_q, rx_d;
  logic [7:0]            delay_q, delay_d;
  logic                  dummy_q, dummy_d;
  logic [15:0]           word_q, word_d;
  logic                  out_valid_q;
  gdsc_res_t             res_q, res_d;

  logic [7:0]  half_ticks;
  logic        maj;
  logic        start;
  logic [15:0] start_word;
  logic        done;
  logic        in_frame;
  logic        fire;

  assign fire        = in_valid_i && (!out_valid_q || out_ready_i);
  assign take_o      = fire;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  assign half_ticks = (half_q == 8'd0) ? 8'd1 : half_q;
  assign maj = (item_i.miso_samples[0] & item_i.miso_samples[1]) |
               (item_i.miso_samples[0] & item_i.miso_samples[2]) |
               (item_i.miso_samples[1] & item_i.miso_samples[2]);

  always_comb begin
    phase_d    = phase_q;
    bit_d      = bit_q;
    tx_d       = tx_q;
    rx_d       = rx_q;
    delay_d    = delay_q;
    dummy_d    = dummy_q;
    word_d     = word_q;
    done       = 1'b0;
    start      = 1'b0;
    start_word = DUMMY_WORD;
    case (phase_q)
      PH_SETUP: begin
        phase_d = PH_HIGH;
        delay_d = half_ticks;
      end
      PH_HIGH: begin
        if (delay_q > 8'd1) begin
          delay_d = delay_q - 8'd1;
        end else begin
          rx_d    = {rx_q[FRAME_BITS-2:0], maj};
          phase_d = PH_LOW;
          delay_d = half_ticks;
        end
      end
      PH_LOW: begin
        if (delay_q > 8'd1) begin
          delay_d = delay_q - 8'd1;
        end else if (bit_q == LastBit) begin
          word_d  = 16'(rx_q);
          phase_d = dummy_q ? PH_GAP : PH_IDLE;
          done    = !dummy_q;
          delay_d = 8'd0;
        end else begin
          bit_d   = bit_q + CntW'(1);
          tx_d    = {tx_q[FRAME_BITS-2:0], 1'b0};
          phase_d = PH_SETUP;
          delay_d = 8'd0;
        end
      end
      PH_GAP: begin
        dummy_d    = 1'b0;
        start      = 1'b1;
        start_word = DUMMY_WORD;
      end
      default: begin
        phase_d = PH_IDLE;
        if (item_i.cmd == CMD_WRITE) begin
          dummy_d    = 1'b0;
          start      = 1'b1;
          start_word = {1'b0, item_i.reg_addr, item_i.write_data};
        end else if (item_i.cmd == CMD_READ) begin
          start = 1'b1;
          if (item_i.reg_addr != 4'd0) begin
            dummy_d    = 1'b1;
            start_word = READ_CMD_BASE | (16'(item_i.reg_addr) << ADDR_LSB);
          end else begin
            dummy_d    = 1'b0;
            start_word = DUMMY_WORD;
          end
        end
      end
    endcase

    if (start) begin
      tx_d    = FRAME_BITS'(start_word);
      rx_d    = '0;
      bit_d   = '0;
      delay_d = 8'd0;
      phase_d = PH_SETUP;
    end

    in_frame = (phase_d == PH_SETUP) || (phase_d == PH_HIGH) || (phase_d == PH_LOW);
    res_d.cs_n      = !in_frame;
    res_d.sck       = (phase_d == PH_HIGH);
    res_d.mosi      = in_frame & tx_d[FRAME_BITS-1];
    res_d.busy_res  = (phase_d != PH_IDLE);
    res_d.done_res  = done;
    res_d.read_data = word_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q      <= HALF_PERIOD_RESET;
      phase_q     <= PH_IDLE;
      bit_q       <= '0;
      tx_q        <= '0;
      rx_q        <= '0;
      delay_q     <= 8'd0;
      dummy_q     <= 1'b0;
      word_q      <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        half_q <= cfg_wdata_i;
      end
      if (fire) begin
        phase_q     <= phase_d;
        bit_q       <= bit_d;
        tx_q        <= tx_d;
        rx_q        <= rx_d;
        delay_q     <= delay_d;
        dummy_q     <= dummy_d;
        word_q      <= word_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  a_setup_to_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && phase_q == PH_SETUP |=> phase_q == PH_HIGH)
    else $error("setup tick not followed by clock high");

  a_gap_starts_dummy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && phase_q == PH_GAP |=> phase_q == PH_SETUP && !dummy_q && bit_q == '0)
    else $error("frame gap did not start the dummy frame");

  a_write_single_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && phase_q == PH_IDLE && item_i.cmd == CMD_WRITE |=> phase_q == PH_SETUP && !dummy_q)
    else $error("write command did not start a single frame");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && done |-> phase_d == PH_IDLE && phase_q == PH_LOW)
    else $error("done raised outside the last low tick");

  a_delay_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HIGH || phase_q == PH_LOW) |-> delay_q != 8'd0)
    else $error("half-period counter empty while clock phase active");

endmodule
